[src/ngps_pkg.sv]
`timescale 1ns / 1ps

package ngps_pkg;

    localparam int COUNT_W = 9;
    localparam int COORD_W = 16;
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 33;
    localparam int WORD_W  = 32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [7:0]                 entry_index;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         best_index;
        logic [DIST_W-1:0]  best_distance_sq;
        logic               found;
    } out_item_t;

    // status of the distance pipeline back to the scan control
    typedef struct packed {
        logic               busy;
        logic               have;
        logic [DIST_W-1:0]  best_d;
    } dist_status_t;

endpackage

[src/ngps_ram.sv]
`timescale 1ns / 1ps

module ngps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/ngps_dist.sv]
`timescale 1ns / 1ps

module ngps_dist #(
    parameter int ADDR_W = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  logic                               issue_valid,
    input  logic [ADDR_W-1:0]                  issue_index,
    input  logic [ngps_pkg::WORD_W-1:0]        rd_data,
    input  logic signed [ngps_pkg::COORD_W-1:0] qx,
    input  logic signed [ngps_pkg::COORD_W-1:0] qy,
    output ngps_pkg::dist_status_t             status,
    output logic [ADDR_W-1:0]                  best_index
);

    // stage a: ram data lines up with this
    logic                        a_valid_reg;
    logic [ADDR_W-1:0]           a_idx_reg;
    // stage b: squared differences
    logic                        b_valid_reg;
    logic [ADDR_W-1:0]           b_idx_reg;
    logic [ngps_pkg::SQ_W-1:0]   b_sqx_reg;
    logic [ngps_pkg::SQ_W-1:0]   b_sqy_reg;
    // running best
    logic                        have_reg;
    logic                        have_next;
    logic [ADDR_W-1:0]           best_idx_reg;
    logic [ADDR_W-1:0]           best_idx_next;
    logic [ngps_pkg::DIST_W-1:0] best_d_reg;
    logic [ngps_pkg::DIST_W-1:0] best_d_next;

    logic signed [ngps_pkg::COORD_W:0]     dx;
    logic signed [ngps_pkg::COORD_W:0]     dy;
    logic signed [2*ngps_pkg::COORD_W+1:0] px2;
    logic signed [2*ngps_pkg::COORD_W+1:0] py2;
    logic [ngps_pkg::DIST_W-1:0]           d_sum;
    logic                                  take;

    always_comb
    begin
        dx  = $signed({rd_data[15], rd_data[15:0]}) - $signed({qx[15], qx});
        dy  = $signed({rd_data[31], rd_data[31:16]}) - $signed({qy[15], qy});
        px2 = dx * dx;
        py2 = dy * dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= issue_index;
        b_idx_reg <= a_idx_reg;
        b_sqx_reg <= px2[ngps_pkg::SQ_W-1:0];
        b_sqy_reg <= py2[ngps_pkg::SQ_W-1:0];
    end

    // strict less-than keeps the lowest index on ties
    always_comb
    begin
        d_sum         = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
        take          = b_valid_reg && (!have_reg || (d_sum < best_d_reg));
        have_next     = have_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        if (clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next     = 1'b1;
            best_idx_next = b_idx_reg;
            best_d_next   = d_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
    end

    always_comb
    begin
        status.busy   = a_valid_reg || b_valid_reg;
        status.have   = have_reg;
        status.best_d = best_d_reg;
        best_index    = best_idx_reg;
    end

endmodule

[src/nearest_grid_point_search_top.sv]
`timescale 1ns / 1ps
// write transaction: stored in the point ram at acceptance
// query transaction: the scan reads n = min(grid_count, GRID_DEPTH) entries, then the distance pipeline drains;
// an empty grid skips the scan; the next input is taken the cycle after the result loads
// throughput set by the scan: one ram read per cycle over the entries in use
// reset: rst_n async active low clears control, count and output valid; ram contents stay
// undefined until written

module nearest_grid_point_search_top #(
    parameter int GRID_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ngps_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ngps_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ngps_pkg::COUNT_W-1:0]        cfg_data
);

    localparam int ADDR_W = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int CNT_W  = $clog2(GRID_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > ngps_pkg::COUNT_W) ? CNT_W : ngps_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration register
    logic [ngps_pkg::COUNT_W-1:0] grid_count_reg;

    // query context
    logic signed [ngps_pkg::COORD_W-1:0] qx_reg;
    logic signed [ngps_pkg::COORD_W-1:0] qy_reg;
    logic [CNT_W-1:0]                    n_reg;
    logic [CNT_W-1:0]                    n_next;
    logic [CNT_W-1:0]                    cnt_reg;
    logic [CNT_W-1:0]                    cnt_next;
    logic [CNT_W-1:0]                    cnt_plus;

    // output slot
    logic                out_valid_reg;
    logic                out_valid_next;
    ngps_pkg::out_item_t out_data_reg;
    ngps_pkg::out_item_t out_data_next;

    logic                in_fire;
    logic                is_query;
    logic                wr_in_range;
    logic                wr_en;
    logic [ADDR_W+7:0]   wr_addr_ext;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ngps_pkg::WORD_W-1:0] rd_data;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    depth_ext;
    logic                clear;
    logic                load_out;

    ngps_pkg::dist_status_t dist_status;
    logic [ADDR_W-1:0]      best_idx;
    logic [ADDR_W+7:0]      best_idx_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign is_query  = (in_data.kind == ngps_pkg::KIND_QUERY);

    // writes beyond the table are dropped
    assign wr_in_range = (32'(in_data.entry_index) < 32'(GRID_DEPTH));
    assign wr_addr_ext = {{ADDR_W{1'b0}}, in_data.entry_index};
    assign wr_addr     = wr_addr_ext[ADDR_W-1:0];
    assign wr_en       = in_fire && !is_query && wr_in_range;

    // entries in use, saturated at the table depth
    assign count_ext = CMP_W'(grid_count_reg);
    assign depth_ext = CMP_W'(GRID_DEPTH);
    assign n_next    = (count_ext > depth_ext) ? CNT_W'(depth_ext) : CNT_W'(count_ext);

    assign cnt_plus = cnt_reg + CNT_W'(1);
    assign rd_en    = (state_reg == ST_SCAN);
    assign rd_addr  = cnt_reg[ADDR_W-1:0];
    assign clear    = in_fire && is_query;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    ngps_ram #(
        .WIDTH (ngps_pkg::WORD_W),
        .DEPTH (GRID_DEPTH)
    ) u_points (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_data.point_y, in_data.point_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ngps_dist #(
        .ADDR_W (ADDR_W)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (clear),
        .issue_valid (rd_en),
        .issue_index (rd_addr),
        .rd_data     (rd_data),
        .qx          (qx_reg),
        .qy          (qy_reg),
        .status      (dist_status),
        .best_index  (best_idx)
    );

    // scan sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire && is_query)
                begin
                    // empty grid skips the scan
                    state_next = (n_next == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_plus;
                if (cnt_plus == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the distance pipeline to settle
                if (!dist_status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result formatting, not-found case reads as all zero
    assign best_idx_ext = {8'd0, best_idx};

    always_comb
    begin
        out_data_next = out_data_reg;
        if (load_out)
        begin
            out_data_next.found            = dist_status.have;
            out_data_next.best_index       = dist_status.have ? best_idx_ext[7:0] : 8'd0;
            out_data_next.best_distance_sq = dist_status.have ? dist_status.best_d
                                                              : '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            grid_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                grid_count_reg <= cfg_data;
            end
        end
    end

    // query context and result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (clear)
        begin
            qx_reg <= in_data.point_x;
            qy_reg <= in_data.point_y;
            n_reg  <= n_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a new query never finds old reads still in the distance pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !dist_status.busy)
    else $error("distance pipeline busy at query start");

    // the result is taken only after the pipeline has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!dist_status.busy && !rd_en))
    else $error("result loaded while reads are in flight");

    // a not-found result carries zero index and zero distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |->
            (out_data.best_index == 8'd0 && out_data.best_distance_sq == '0))
    else $error("not-found result with nonzero payload");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int  CLK_PERIOD    = 10;
    localparam int  RESET_CYCLES  = 7;
    localparam int  GRID_DEPTH    = 256;
    localparam int  RANDOM_ITEMS  = 380;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 40;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  MAX_GAP       = 20;
    localparam int  REPORT_LIMIT  = 10;
    // worst case: ~650 transactions, each a full 256-entry scan plus both stalls, wide margin
    localparam int  CYCLE_LIMIT   = 1500000;
    // the scan starts from this distance, squared
    localparam longint SEARCH_CAP = 64'd2000000;

    // one row of the directed stimulus: a register write or an input transaction,
    // optionally with the result written out by hand
    typedef struct {
        bit                                 is_cfg;
        logic [ngps_pkg::COUNT_W-1:0]       cfg_value;
        ngps_pkg::in_item_t                 item;
        bit                                 typed;
        ngps_pkg::out_item_t                result;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    ngps_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    ngps_pkg::out_item_t            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ngps_pkg::COUNT_W-1:0]   cfg_data = '0;

    // predictor state: point table, which entries hold data, and the active count
    logic [ngps_pkg::WORD_W-1:0]    grid_words [GRID_DEPTH];
    bit                             grid_written [GRID_DEPTH];
    logic [ngps_pkg::COUNT_W-1:0]   grid_count_model = '0;

    ngps_pkg::out_item_t            pending_results [$];
    stim_row_t                      directed_rows [$];

    int                  errors = 0;
    int                  cycle_count = 0;
    int                  send_idle_pct = 34;
    int                  recv_idle_pct = 68;
    int                  hold_asks = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    nearest_grid_point_search_top #(
        .GRID_DEPTH (GRID_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // brute-force scan over the entries in use, lowest index kept on a tie
    function automatic ngps_pkg::out_item_t nearest_of(input ngps_pkg::in_item_t query);
        ngps_pkg::out_item_t res;
        int        span;
        longint    dx;
        longint    dy;
        longint    d;
        longint    best_d;
        int        best_i;
        bit        have;
        span   = (grid_count_model > GRID_DEPTH) ? GRID_DEPTH : int'(grid_count_model);
        best_d = SEARCH_CAP * SEARCH_CAP;
        best_i = 0;
        have   = 1'b0;
        for (int i = 0; i < span; i++)
        begin
            dx = longint'($signed(query.point_x)) - longint'($signed(grid_words[i][15:0]));
            dy = longint'($signed(query.point_y)) - longint'($signed(grid_words[i][31:16]));
            d  = dx * dx + dy * dy;
            if (d < best_d)
            begin
                best_d = d;
                best_i = i;
                have   = 1'b1;
            end
        end
        if (!have)
        begin
            best_i = 0;
            best_d = 0;
        end
        res.best_index       = best_i[7:0];
        res.best_distance_sq = best_d[ngps_pkg::DIST_W-1:0];
        res.found            = have;
        return res;
    endfunction

    // coordinates: full range, a tight cluster around zero for ties, or an extreme
    function automatic logic signed [ngps_pkg::COORD_W-1:0] rand_coord();
        int pick;
        int v;
        pick = $urandom_range(9);
        if (pick < 4)
            v = $urandom();
        else if (pick < 8)
            v = int'($urandom_range(8)) - 4;
        else if (pick == 8)
            v = $urandom_range(1) ? 32767 : -32768;
        else
            v = $urandom_range(1) ? -1 : 0;
        return v[ngps_pkg::COORD_W-1:0];
    endfunction

    function automatic stim_row_t cfg_row(input int value);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_value = value[ngps_pkg::COUNT_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t write_row(input int idx, input int x, input int y);
        stim_row_t row;
        row = '{default: '0};
        row.item.kind        = ngps_pkg::KIND_WRITE;
        row.item.entry_index = idx[7:0];
        row.item.point_x     = x[ngps_pkg::COORD_W-1:0];
        row.item.point_y     = y[ngps_pkg::COORD_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t query_row(input int x, input int y, input bit typed,
                                            input int idx, input longint dist_sq,
                                            input bit hit);
        stim_row_t row;
        row = '{default: '0};
        row.item.kind               = ngps_pkg::KIND_QUERY;
        row.item.entry_index        = 8'hFF;
        row.item.point_x            = x[ngps_pkg::COORD_W-1:0];
        row.item.point_y            = y[ngps_pkg::COORD_W-1:0];
        row.typed                   = typed;
        row.result.best_index       = idx[7:0];
        row.result.best_distance_sq = dist_sq[ngps_pkg::DIST_W-1:0];
        row.result.found            = hit;
        return row;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // present one input transaction, hold it until taken, then update the predictor
    task automatic offer_item(input ngps_pkg::in_item_t item, input bit typed,
                              input ngps_pkg::out_item_t typed_result);
        int gap;
        gap = 0;
        @(negedge clk);
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = item;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (item.kind == ngps_pkg::KIND_WRITE)
        begin
            grid_words[item.entry_index]   = {item.point_y, item.point_x};
            grid_written[item.entry_index] = 1'b1;
        end
        else
        begin
            pending_results.insert(pending_results.size(),
                                   typed ? typed_result : nearest_of(item));
        end
    endtask

    // count register is written only with the block idle and nothing outstanding
    task automatic set_grid_count(input logic [ngps_pkg::COUNT_W-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a trailing write transaction may still be settling
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        grid_count_model = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random back-pressure, or a long hold-off when the stimulus asks for one
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // each result transaction is matched against the oldest outstanding expectation
    always @(posedge clk)
    begin : result_check
        ngps_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: index %0d dist %0d found %0b",
                             out_data.best_index, out_data.best_distance_sq, out_data.found);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.best_index !== want.best_index ||
                    out_data.best_distance_sq !== want.best_distance_sq ||
                    out_data.found !== want.found)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("mismatch: index %0d/%0d dist %0d/%0d found %0b/%0b (exp/act)",
                                 want.best_index, out_data.best_index,
                                 want.best_distance_sq, out_data.best_distance_sq,
                                 want.found, out_data.found);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        int                  seg;
        int                  eff;
        int                  n_items;
        int                  random_sent;
        int                  r;
        logic [8:0]          count_pick;
        ngps_pkg::in_item_t  item;

        seg         = 0;
        random_sent = 0;

        // directed part: empty grid after reset, extreme coordinates and the largest
        // distance, exact hits, a tie between equidistant entries, and back to empty
        add_row(query_row(0, 0, 1'b1, 0, 0, 1'b0));
        add_row(query_row(-32768, 32767, 1'b1, 0, 0, 1'b0));
        add_row(write_row(0, -32768, -32768));
        add_row(write_row(1, 32767, 32767));
        add_row(write_row(2, 0, 0));
        add_row(write_row(3, -32768, 32767));
        add_row(write_row(4, 32767, -32768));
        add_row(cfg_row(1));
        add_row(query_row(32767, 32767, 1'b1, 0, 64'd8589672450, 1'b1));
        add_row(cfg_row(5));
        add_row(query_row(-32768, -32768, 1'b1, 0, 0, 1'b1));
        add_row(query_row(32767, 32767, 1'b1, 1, 0, 1'b1));
        add_row(query_row(-32768, 32767, 1'b1, 3, 0, 1'b1));
        add_row(query_row(32767, -32768, 1'b1, 4, 0, 1'b1));
        add_row(query_row(100, -200, 1'b0, 0, 0, 1'b0));
        add_row(write_row(5, 2, 0));
        add_row(cfg_row(6));
        // (0,0) at entry 2 and (2,0) at entry 5 are both at distance 1: lower index wins
        add_row(query_row(1, 0, 1'b1, 2, 1, 1'b1));
        add_row(query_row(-1, 1, 1'b0, 0, 0, 1'b0));
        add_row(write_row(255, -1, -1));
        add_row(cfg_row(0));
        add_row(query_row(5, 5, 1'b1, 0, 0, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_grid_count(directed_rows[i].cfg_value);
            else
                offer_item(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].result);
        end

        // random part: segments, each with its own count setting; every entry in use
        // is written before any query can scan it
        while (random_sent < RANDOM_ITEMS)
        begin
            unique case (seg)
                0: count_pick = 9'd3;
                1: count_pick = 9'd256;
                2: count_pick = 9'd511;
                3: count_pick = 9'd0;
                4: count_pick = 9'd1;
                5: count_pick = 9'd255;
                6: count_pick = 9'd257;
                default:
                begin
                    r = $urandom_range(99);
                    if (r < 5)
                        count_pick = 9'd0;
                    else if (r < 60)
                        count_pick = 9'($urandom_range(8, 1));
                    else if (r < 85)
                        count_pick = 9'($urandom_range(64, 9));
                    else if (r < 93)
                        count_pick = 9'($urandom_range(255, 65));
                    else
                        count_pick = 9'($urandom_range(511, 256));
                end
            endcase
            set_grid_count(count_pick);
            eff = (count_pick > GRID_DEPTH) ? GRID_DEPTH : int'(count_pick);

            for (int i = 0; i < eff; i++)
            begin
                if (!grid_written[i])
                begin
                    item.kind        = ngps_pkg::KIND_WRITE;
                    item.entry_index = i[7:0];
                    item.point_x     = rand_coord();
                    item.point_y     = rand_coord();
                    offer_item(item, 1'b0, '0);
                end
            end

            // first segment: receiver stops for a long stretch so the block backs up
            if (seg == 0)
                hold_asks++;

            n_items = $urandom_range(40, 12);
            for (int k = 0; k < n_items && random_sent < RANDOM_ITEMS; k++)
            begin
                if (random_sent < RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 68;
                end
                else if (random_sent < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 34;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                item.kind = ($urandom_range(99) < 60) ? ngps_pkg::KIND_QUERY
                                                      : ngps_pkg::KIND_WRITE;
                // most writes land inside the live range so results keep moving
                if (item.kind == ngps_pkg::KIND_WRITE && eff > 0 && $urandom_range(99) < 70)
                    item.entry_index = 8'($urandom_range(eff - 1));
                else
                    item.entry_index = 8'($urandom_range(255));
                item.point_x = rand_coord();
                item.point_y = rand_coord();
                offer_item(item, 1'b0, '0);
                random_sent++;
            end
            seg++;
        end

        // drain: everything outstanding, then a quiet window for stray results
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
